// ----- design/color_baseline_classifier_unit_macros.svh -----
// Assertion macros shared by the color baseline classifier RTL.
`ifndef COLOR_BASELINE_CLASSIFIER_UNIT_MACROS_SVH
`define COLOR_BASELINE_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cbc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cbc assertion failed");

`endif

// ----- design/cbc_pkg.sv -----
// Shared widths, codes and types of the color baseline classifier.
`default_nettype none

package cbc_pkg;

  localparam int LEVEL_W   = 24;
  localparam int THR_W     = 16;
  localparam int FRAC_W    = 12;
  localparam int SUM_W     = 30;
  localparam int COLOR_W   = 2;
  localparam int CFG_IDX_W = 2;

  // Product widths of the cross-multiplication.
  localparam int LB_W  = LEVEL_W + LEVEL_W;
  localparam int TB_W  = LEVEL_W + THR_W;
  localparam int DL_W  = LEVEL_W + THR_W;
  localparam int DLB_W = DL_W + LEVEL_W;

  localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_BLUE  = 2'd2;
  localparam logic [COLOR_W-1:0] COLOR_NONE  = 2'd3;

  localparam logic ACT_CALIB    = 1'b0;
  localparam logic ACT_CLASSIFY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOM_THR   = 2'd1;

  localparam logic [THR_W-1:0] LEVEL_THR_RST = 16'd4710;
  localparam logic [THR_W-1:0] DOM_THR_RST   = 16'd4301;

  // Index 0 red, 1 green, 2 blue.
  typedef logic [2:0][LEVEL_W-1:0] levels_t;

  typedef struct packed {
    logic busy;
    logic done;
  } calib_status_t;

  typedef struct packed {
    logic               busy;
    logic [COLOR_W-1:0] color;
  } cls_status_t;

endpackage

`default_nettype wire

// ----- design/cbc_in_if.sv -----
// Input channel interface: one reading or calibration word per handshake.
`default_nettype none

interface cbc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [cbc_pkg::LEVEL_W-1:0] red_level;
  logic [cbc_pkg::LEVEL_W-1:0] green_level;
  logic [cbc_pkg::LEVEL_W-1:0] blue_level;
  logic [cbc_pkg::COLOR_W-1:0] target_color;

  modport source (
    output valid, action, red_level, green_level, blue_level, target_color,
    input  ready
  );
  modport sink (
    input  valid, action, red_level, green_level, blue_level, target_color,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/cbc_out_if.sv -----
// Output channel interface: one result word per handshake.
`default_nettype none

interface cbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [cbc_pkg::COLOR_W-1:0] detected_color;
  logic                        matches_target;
  logic                        calibration_done;

  modport source (
    output valid, detected_color, matches_target, calibration_done,
    input  ready
  );
  modport sink (
    input  valid, detected_color, matches_target, calibration_done,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/cbc_smul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per step.
`default_nettype none

module cbc_smul #(
  parameter int AW = 24,
  parameter int BW = 24
) (
  input  wire logic             clk_i,
  input  wire logic             start_i,
  input  wire logic             step_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output logic      [AW+BW-1:0] p_o
);

  // The low half starts as the multiplier and empties as product bits shift in.
  logic [AW+BW-1:0] p_q, p_d;
  logic [AW:0]      sum;

  always_comb begin
    sum = {1'b0, p_q[AW+BW-1:BW]} + (p_q[0] ? {1'b0, a_i} : {(AW+1){1'b0}});
    p_d = p_q;
    if (start_i) begin
      p_d = {{AW{1'b0}}, b_i};
    end else if (step_i) begin
      p_d = {sum, p_q[BW-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- design/cbc_calib.sv -----
// Calibration: channel sums, sample count and serial divide into baselines.
`default_nettype none

`include "color_baseline_classifier_unit_macros.svh"

module cbc_calib #(
  parameter int CALIB_SAMPLES = 50
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     add_i,
  input  wire cbc_pkg::levels_t         levels_i,
  output cbc_pkg::levels_t              baselines_o,
  output cbc_pkg::calib_status_t        status_o
);

  localparam int RemW    = (CALIB_SAMPLES > 1) ? $clog2(CALIB_SAMPLES) : 1;
  localparam int CntW    = $clog2(CALIB_SAMPLES + 1);
  localparam int DivCntW = $clog2(cbc_pkg::SUM_W);

  logic [cbc_pkg::SUM_W-1:0]   sum_q [3];
  logic [RemW-1:0]             rem_q [3];
  logic [cbc_pkg::LEVEL_W-1:0] base_q [3];
  logic [CntW-1:0]             cnt_q;
  logic [DivCntW-1:0]          div_cnt_q;
  logic                        busy_q;
  logic                        done_q;

  logic [RemW:0]               trial [3];
  logic [RemW:0]               diff [3];
  logic                        ge [3];
  logic [RemW-1:0]             rem_d [3];
  logic [cbc_pkg::SUM_W-1:0]   shifted [3];

  // One restoring-division step per cycle; the sum register shifts out its
  // dividend bits from the top and takes the quotient bits in at the bottom.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c]   = {rem_q[c], sum_q[c][cbc_pkg::SUM_W-1]};
      ge[c]      = (trial[c] >= (RemW+1)'(CALIB_SAMPLES));
      diff[c]    = trial[c] - (RemW+1)'(CALIB_SAMPLES);
      rem_d[c]   = ge[c] ? diff[c][RemW-1:0] : trial[c][RemW-1:0];
      shifted[c] = {sum_q[c][cbc_pkg::SUM_W-2:0], ge[c]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c]  <= '0;
        rem_q[c]  <= '0;
        base_q[c] <= '0;
      end
      cnt_q     <= '0;
      div_cnt_q <= '0;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
    end else if (add_i) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= sum_q[c] + cbc_pkg::SUM_W'(levels_i[c]);
        rem_q[c] <= '0;
      end
      div_cnt_q <= '0;
      if (cnt_q == CntW'(CALIB_SAMPLES - 1)) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
        done_q <= 1'b1;
      end else begin
        cnt_q  <= cnt_q + 1'b1;
        done_q <= 1'b0;
      end
    end else if (busy_q) begin
      for (int c = 0; c < 3; c++) begin
        rem_q[c] <= rem_d[c];
        sum_q[c] <= shifted[c];
      end
      div_cnt_q <= div_cnt_q + 1'b1;
      if (div_cnt_q == DivCntW'(cbc_pkg::SUM_W - 1)) begin
        busy_q <= 1'b0;
        for (int c = 0; c < 3; c++) begin
          base_q[c] <= shifted[c][cbc_pkg::LEVEL_W-1:0];
          sum_q[c]  <= '0;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      baselines_o[c] = base_q[c];
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

  `CBC_ASSERT_IMPL(a_count_clear_while_dividing, clk_i, rst_ni, busy_q, cnt_q == '0)
  `CBC_ASSERT_IMPL(a_no_sample_while_dividing, clk_i, rst_ni, add_i, !busy_q)
  `CBC_ASSERT_NEXT(a_run_end_sets_done, clk_i, rst_ni, add_i && busy_q == 1'b0 && cnt_q == CntW'(CALIB_SAMPLES - 1), busy_q && done_q)

endmodule

`default_nettype wire

// ----- design/cbc_classify.sv -----
// Classification: serial cross-products against the baselines, then compares.
`default_nettype none

`include "color_baseline_classifier_unit_macros.svh"

module cbc_classify (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire cbc_pkg::levels_t            levels_i,
  input  wire cbc_pkg::levels_t            base_i,
  input  wire logic [cbc_pkg::THR_W-1:0]   level_thr_i,
  input  wire logic [cbc_pkg::THR_W-1:0]   dom_thr_i,
  output cbc_pkg::cls_status_t             status_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_A    = 2'd1;
  localparam logic [1:0] PH_B    = 2'd2;
  localparam logic [1:0] PH_CMP  = 2'd3;

  localparam int StepW = $clog2(cbc_pkg::LEVEL_W);

  logic [1:0]                   phase_q;
  logic [StepW-1:0]             cnt_q;
  logic [cbc_pkg::COLOR_W-1:0]  color_q;
  logic [cbc_pkg::COLOR_W-1:0]  color_d;

  logic step_a, step_a_short, load_b, step_b, last_step;

  logic [cbc_pkg::DL_W-1:0]  dl  [3];
  logic [cbc_pkg::TB_W-1:0]  tb  [3];
  logic [cbc_pkg::LB_W-1:0]  lb  [3][2];
  logic [cbc_pkg::DLB_W-1:0] dlb [3][2];

  assign last_step    = (cnt_q == StepW'(cbc_pkg::LEVEL_W - 1));
  assign step_a       = (phase_q == PH_A);
  assign step_a_short = step_a && (cnt_q < StepW'(cbc_pkg::THR_W));
  assign load_b       = step_a && last_step;
  assign step_b       = (phase_q == PH_B);

  // Phase A forms D*L[j], T*B[i] and L[i]*B[j]; phase B forms D*L[j]*B[i].
  for (genvar i = 0; i < 3; i++) begin : g_chan
    cbc_smul #(.AW(cbc_pkg::LEVEL_W), .BW(cbc_pkg::THR_W)) u_dl (
      .clk_i   (clk_i),
      .start_i (start_i),
      .step_i  (step_a_short),
      .a_i     (levels_i[i]),
      .b_i     (dom_thr_i),
      .p_o     (dl[i])
    );
    cbc_smul #(.AW(cbc_pkg::LEVEL_W), .BW(cbc_pkg::THR_W)) u_tb (
      .clk_i   (clk_i),
      .start_i (start_i),
      .step_i  (step_a_short),
      .a_i     (base_i[i]),
      .b_i     (level_thr_i),
      .p_o     (tb[i])
    );
    for (genvar s = 0; s < 2; s++) begin : g_other
      localparam int J = (i + s + 1) % 3;
      cbc_smul #(.AW(cbc_pkg::LEVEL_W), .BW(cbc_pkg::LEVEL_W)) u_lb (
        .clk_i   (clk_i),
        .start_i (start_i),
        .step_i  (step_a),
        .a_i     (base_i[J]),
        .b_i     (levels_i[i]),
        .p_o     (lb[i][s])
      );
      cbc_smul #(.AW(cbc_pkg::DL_W), .BW(cbc_pkg::LEVEL_W)) u_dlb (
        .clk_i   (clk_i),
        .start_i (load_b),
        .step_i  (step_b),
        .a_i     (dl[J]),
        .b_i     (base_i[i]),
        .p_o     (dlb[i][s])
      );
    end
  end

  logic       any_zero;
  logic [2:0] win;

  always_comb begin
    any_zero = 1'b0;
    for (int i = 0; i < 3; i++) begin
      any_zero = any_zero || (base_i[i] == '0);
      win[i] = (cbc_pkg::TB_W'({levels_i[i], {cbc_pkg::FRAC_W{1'b0}}}) >= tb[i])
            && (cbc_pkg::DLB_W'({lb[i][0], {cbc_pkg::FRAC_W{1'b0}}}) >= dlb[i][0])
            && (cbc_pkg::DLB_W'({lb[i][1], {cbc_pkg::FRAC_W{1'b0}}}) >= dlb[i][1]);
    end
    if (any_zero) begin
      color_d = cbc_pkg::COLOR_NONE;
    end else if (win[0]) begin
      color_d = cbc_pkg::COLOR_RED;
    end else if (win[1]) begin
      color_d = cbc_pkg::COLOR_GREEN;
    end else if (win[2]) begin
      color_d = cbc_pkg::COLOR_BLUE;
    end else begin
      color_d = cbc_pkg::COLOR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      color_q <= cbc_pkg::COLOR_NONE;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            phase_q <= PH_A;
            cnt_q   <= '0;
          end
        end
        PH_A: begin
          cnt_q <= last_step ? '0 : cnt_q + 1'b1;
          if (last_step) begin
            phase_q <= PH_B;
          end
        end
        PH_B: begin
          cnt_q <= last_step ? '0 : cnt_q + 1'b1;
          if (last_step) begin
            phase_q <= PH_CMP;
          end
        end
        PH_CMP: begin
          color_q <= color_d;
          phase_q <= PH_IDLE;
        end
        default: begin
          phase_q <= PH_IDLE;
        end
      endcase
    end
  end

  assign status_o.busy  = (phase_q != PH_IDLE);
  assign status_o.color = color_q;

  `CBC_ASSERT_IMPL(a_no_restart_while_busy, clk_i, rst_ni, start_i, phase_q == PH_IDLE)
  `CBC_ASSERT_NEXT(a_phase_a_leads_to_b, clk_i, rst_ni, load_b, phase_q == PH_B && cnt_q == '0)

endmodule

`default_nettype wire

// ----- design/color_baseline_classifier_unit.sv -----
// Top level of the color baseline classifier.
//
//   channel   | dir | handshake     | contents of one word
//   ----------+-----+---------------+-----------------------------------------
//   in_i      | in  | valid/ready   | action, red/green/blue level, target
//   out_o     | out | valid/ready   | detected color, target match, cal. done
//   cfg_*_i   | in  | write enable  | register index and 16-bit data
//
// A classify word runs the serial multipliers in two phases (level and cross
// products, then the threshold-scaled cross products), followed by a compare
// step, before the next word is accepted.
// A calibration word adds to the channel sums; when it closes a run, the
// bit-serial divider turns each sum into a baseline before the word finishes.
// Reset clears the sums, baselines and sample count and loads the default
// thresholds; the block is ready for a word right after reset is released.
// A stalled output holds its word in the output register while the next
// input word is accepted and worked on; only the finishing step waits.
`default_nettype none

`include "color_baseline_classifier_unit_macros.svh"

module color_baseline_classifier_unit #(
  parameter int CALIB_SAMPLES = 50
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  cbc_in_if.sink                               in_i,
  cbc_out_if.source                            out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [cbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cbc_pkg::THR_W-1:0]       cfg_data_i
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CAL_WAIT = 3'd1;
  localparam logic [2:0] ST_CLS_GO   = 3'd2;
  localparam logic [2:0] ST_CLS_WAIT = 3'd3;
  localparam logic [2:0] ST_FINISH   = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [cbc_pkg::THR_W-1:0] level_thr_q;
  logic [cbc_pkg::THR_W-1:0] dom_thr_q;

  // The accepted word is held here while the serial units work on it.
  cbc_pkg::levels_t             levels_q;
  logic                         action_q;
  logic [cbc_pkg::COLOR_W-1:0]  target_q;

  // Output register, which frees the input side while a result waits.
  logic                         out_valid_q;
  logic [cbc_pkg::COLOR_W-1:0]  det_q;
  logic                         match_q;
  logic                         done_q;

  logic                         accept;
  logic                         out_free;
  cbc_pkg::levels_t             in_levels;
  cbc_pkg::levels_t             baselines;
  cbc_pkg::calib_status_t       cal_status;
  cbc_pkg::cls_status_t         cls_status;
  logic [cbc_pkg::COLOR_W-1:0]  res_color;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_levels  = {in_i.blue_level, in_i.green_level, in_i.red_level};

  cbc_calib #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_calib (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .add_i       (accept && (in_i.action == cbc_pkg::ACT_CALIB)),
    .levels_i    (in_levels),
    .baselines_o (baselines),
    .status_o    (cal_status)
  );

  cbc_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (state_q == ST_CLS_GO),
    .levels_i    (levels_q),
    .base_i      (baselines),
    .level_thr_i (level_thr_q),
    .dom_thr_i   (dom_thr_q),
    .status_o    (cls_status)
  );

  // Calibration words always report no color; classify words never report done.
  assign res_color = (action_q == cbc_pkg::ACT_CALIB) ? cbc_pkg::COLOR_NONE
                                                      : cls_status.color;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_i.action == cbc_pkg::ACT_CALIB) ? ST_CAL_WAIT : ST_CLS_GO;
        end
      end
      ST_CAL_WAIT: begin
        if (!cal_status.busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_CLS_GO: begin
        state_d = ST_CLS_WAIT;
      end
      ST_CLS_WAIT: begin
        if (!cls_status.busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_thr_q <= cbc_pkg::LEVEL_THR_RST;
      dom_thr_q   <= cbc_pkg::DOM_THR_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cbc_pkg::REG_LEVEL_THR: level_thr_q <= cfg_data_i;
          cbc_pkg::REG_DOM_THR:   dom_thr_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      levels_q <= in_levels;
      action_q <= in_i.action;
      target_q <= in_i.target_color;
    end
    if ((state_q == ST_FINISH) && out_free) begin
      det_q   <= res_color;
      match_q <= (action_q == cbc_pkg::ACT_CLASSIFY) && (res_color == target_q);
      done_q  <= (action_q == cbc_pkg::ACT_CALIB) && cal_status.done;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.detected_color   = det_q;
  assign out_o.matches_target   = match_q;
  assign out_o.calibration_done = done_q;

  `CBC_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_i.valid && in_i.ready, state_q != ST_IDLE)
  `CBC_ASSERT_NEXT(a_finish_loads_output, clk_i, rst_ni, state_q == ST_FINISH && out_free, out_valid_q)
  `CBC_ASSERT_IMPL(a_done_reports_no_color, clk_i, rst_ni, out_valid_q && done_q, det_q == cbc_pkg::COLOR_NONE && !match_q)

endmodule

`default_nettype wire

// ----- test/color_baseline_classifier_unit_test.sv -----
// Self-checking testbench of the color baseline classifier: directed and random words checked against a built-in predictor.
`timescale 1ns / 100ps

module color_baseline_classifier_unit_test;
  import cbc_pkg::*;

  // Run parameters. The block is built with the standard calibration length.
  localparam int CAL_RUN          = 50;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES      = 64;
  localparam int MAX_REPORTS      = 10;
  localparam int PHASE_WORDS      = 350;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam logic [63:0]        Q12_ONE   = 64'd1 << FRAC_W;

  // Register indexes that the block has no register behind.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Element i is the color code of channel i (red, green, blue).
  localparam logic [2:0][COLOR_W-1:0] CHANNEL_COLOR = {COLOR_BLUE, COLOR_GREEN, COLOR_RED};

  typedef struct packed {
    logic               action;
    levels_t            levels;
    logic [COLOR_W-1:0] target;
  } reading_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               match;
    logic               cal_done;
  } verdict_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [THR_W-1:0]     cfg_data;

  cbc_in_if  reading_ch ();
  cbc_out_if verdict_ch ();

  color_baseline_classifier_unit #(
    .CALIB_SAMPLES(CAL_RUN)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (reading_ch),
    .out_o     (verdict_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // Predictor copy of the block's state and registers.
  logic [SUM_W-1:0]   ch_sum  [3];
  logic [LEVEL_W-1:0] ch_base [3];
  logic [9:0]         samples_taken;
  logic [THR_W-1:0]   level_thr;
  logic [THR_W-1:0]   dom_thr;

  // Results predicted for accepted words, oldest first.
  verdict_t pending_verdicts [$];

  // Traffic shaping, shared with the receiver process.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit long_hold      = 1'b0;

  // Bookkeeping for the summary and the final verdict.
  int failures      = 0;
  int words_sent    = 0;
  int calib_words   = 0;
  int classify_words = 0;
  int runs_closed   = 0;
  int settings_used = 0;
  int color_hits [4] = '{0, 0, 0, 0};

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Cross-multiplied ratio test: reading i over baseline i beats reading j over
  // baseline j by at least the dominance threshold. A zero reading on channel j
  // makes the right side zero, so this passes.
  function automatic logic ratio_dominates(levels_t lv, int i, int j);
    logic [63:0] li, lj, bi, bj, dt, lhs, rhs;
    li  = lv[i];
    lj  = lv[j];
    bi  = ch_base[i];
    bj  = ch_base[j];
    dt  = dom_thr;
    lhs = li * bj * Q12_ONE;
    rhs = dt * lj * bi;
    return lhs >= rhs;
  endfunction

  // First channel in red, green, blue order that clears the level test and
  // dominates both others. Nothing is detected while any baseline is zero.
  function automatic logic [COLOR_W-1:0] dominant_color(levels_t lv);
    logic [63:0] scaled, floor_level;
    for (int i = 0; i < 3; i++) begin
      if (ch_base[i] == '0) return COLOR_NONE;
    end
    for (int i = 0; i < 3; i++) begin
      scaled      = lv[i];
      scaled      = scaled * Q12_ONE;
      floor_level = level_thr;
      floor_level = floor_level * ch_base[i];
      if (scaled >= floor_level && ratio_dominates(lv, i, (i + 1) % 3) &&
          ratio_dominates(lv, i, (i + 2) % 3)) begin
        return CHANNEL_COLOR[i];
      end
    end
    return COLOR_NONE;
  endfunction

  // Advances the predictor by one accepted word and returns its result word.
  function automatic verdict_t expected_verdict(reading_t r);
    verdict_t v;
    v.color    = COLOR_NONE;
    v.match    = 1'b0;
    v.cal_done = 1'b0;
    if (r.action == ACT_CALIB) begin
      for (int i = 0; i < 3; i++) ch_sum[i] = ch_sum[i] + r.levels[i];
      samples_taken = samples_taken + 1'b1;
      if (samples_taken >= CAL_RUN) begin
        for (int i = 0; i < 3; i++) begin
          ch_base[i] = ch_sum[i] / CAL_RUN;
          ch_sum[i]  = '0;
        end
        samples_taken = '0;
        v.cal_done    = 1'b1;
      end
    end else begin
      v.color = dominant_color(r.levels);
      v.match = (v.color == r.target);
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Word generators
  // ---------------------------------------------------------------------------

  function automatic logic [LEVEL_W-1:0] clamp_level(logic [63:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v[LEVEL_W-1:0];
  endfunction

  function automatic reading_t make_reading(logic action, logic [LEVEL_W-1:0] red,
                                            logic [LEVEL_W-1:0] green,
                                            logic [LEVEL_W-1:0] blue,
                                            logic [COLOR_W-1:0] target);
    reading_t r;
    r.action = action;
    r.levels = {blue, green, red};
    r.target = target;
    return r;
  endfunction

  // Every bit of every field random: noise words of either kind.
  function automatic reading_t random_reading();
    reading_t r;
    r.action = $urandom_range(0, 1);
    r.levels = {$urandom(), $urandom(), $urandom()};
    r.target = $urandom_range(0, 3);
    return r;
  endfunction

  // Classify word whose readings sit around the current baselines, with one
  // channel pushed up so that the thresholds actually decide the outcome.
  function automatic reading_t shaped_classify();
    reading_t    r;
    int          lead;
    logic [63:0] v, fac;
    r.action = ACT_CLASSIFY;
    r.target = $urandom_range(0, 3);
    lead     = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 9))
        0: r.levels[i] = '0;
        1: r.levels[i] = $urandom();
        default: begin
          fac = (i == lead) ? $urandom_range(4096, 7168) : $urandom_range(2048, 5120);
          v   = ch_base[i];
          v   = (v * fac) >> FRAC_W;
          r.levels[i] = clamp_level(v);
        end
      endcase
    end
    return r;
  endfunction

  // Typical ambient level for a random calibration run, with the extremes.
  function automatic logic [LEVEL_W-1:0] random_base();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return $urandom();
      3:       return LEVEL_MAX;
      default: return $urandom_range(1, 300000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  task automatic drive_payload(reading_t r);
    reading_ch.action       <= r.action;
    reading_ch.red_level    <= r.levels[0];
    reading_ch.green_level  <= r.levels[1];
    reading_ch.blue_level   <= r.levels[2];
    reading_ch.target_color <= r.target;
  endtask

  // Offers one word, after an optional random gap with garbage on the payload,
  // and returns at the edge where it was taken. Valid is left high so that a
  // following word can be offered back to back.
  task automatic send_reading(reading_t r);
    verdict_t v;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      reading_ch.valid <= 1'b0;
      do begin
        drive_payload(random_reading());
        @(posedge clk_i);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    reading_ch.valid <= 1'b1;
    drive_payload(r);
    @(posedge clk_i);
    while (!reading_ch.ready) @(posedge clk_i);
    v = expected_verdict(r);
    pending_verdicts.push_back(v);
    words_sent++;
    if (r.action == ACT_CALIB) begin
      calib_words++;
      if (v.cal_done) runs_closed++;
    end else begin
      classify_words++;
      color_hits[v.color]++;
    end
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain_results();
    reading_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  // One register write; only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    if (idx == REG_LEVEL_THR) begin
      level_thr = data;
      settings_used++;
    end else if (idx == REG_DOM_THR) begin
      dom_thr = data;
      settings_used++;
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Completes the calibration run in progress with samples around the given
  // base levels. The noise is base >> noise_shift either way; classify words
  // are mixed in at the given percentage and must leave the run alone.
  task automatic run_calibration(logic [LEVEL_W-1:0] red, logic [LEVEL_W-1:0] green,
                                 logic [LEVEL_W-1:0] blue, int noise_shift,
                                 int classify_pct);
    levels_t     base;
    reading_t    s;
    logic [63:0] span, v;
    int          remaining;
    base      = {blue, green, red};
    remaining = CAL_RUN - samples_taken;
    while (remaining > 0) begin
      if ($urandom_range(0, 99) < classify_pct) begin
        send_reading(shaped_classify());
      end else begin
        s.action = ACT_CALIB;
        s.target = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) begin
          span = base[i] >> noise_shift;
          v    = base[i];
          v    = v - span + $urandom_range(0, 2 * span);
          s.levels[i] = clamp_level(v);
        end
        send_reading(s);
        remaining--;
      end
    end
  endtask

  task automatic randomize_thresholds();
    logic [THR_W-1:0] lvl, dom;
    case ($urandom_range(0, 9))
      0:       lvl = '0;
      1:       lvl = '1;
      2:       lvl = $urandom();
      default: lvl = $urandom_range(4096, 6144);
    endcase
    case ($urandom_range(0, 9))
      0:       dom = '0;
      1:       dom = '1;
      2:       dom = $urandom();
      default: dom = $urandom_range(4096, 5120);
    endcase
    write_reg(REG_LEVEL_THR, lvl);
    write_reg(REG_DOM_THR, dom);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_A, $urandom());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Before the first calibration every baseline is zero, so nothing is found;
  // only a target of none counts as a match.
  task automatic test_uncalibrated();
    send_reading(make_reading(ACT_CLASSIFY, LEVEL_MAX, '0, '0, COLOR_RED));
    send_reading(make_reading(ACT_CLASSIFY, '0, LEVEL_MAX, '0, COLOR_GREEN));
    send_reading(make_reading(ACT_CLASSIFY, '0, '0, LEVEL_MAX, COLOR_BLUE));
    send_reading(make_reading(ACT_CLASSIFY, '0, '0, '0, COLOR_NONE));
  endtask

  // A clean run gives baselines 1000, 2000 and 4000. Two classify words in
  // the middle of the run must not disturb the sums or the sample count.
  task automatic test_first_calibration();
    repeat (20) send_reading(make_reading(ACT_CALIB, 1000, 2000, 4000, $urandom_range(0, 3)));
    send_reading(make_reading(ACT_CLASSIFY, 1200, 2000, 4000, COLOR_RED));
    send_reading(make_reading(ACT_CLASSIFY, 5000, 5000, 5000, COLOR_NONE));
    run_calibration(1000, 2000, 4000, LEVEL_W, 0);
  endtask

  // Each winner, a tie, zero readings, full-scale readings and a near miss
  // where the two leading ratios are too close to each other.
  task automatic test_basic_classify();
    send_reading(make_reading(ACT_CLASSIFY, 1200, 2000, 4000, COLOR_RED));
    send_reading(make_reading(ACT_CLASSIFY, 1000, 2400, 4000, COLOR_RED));
    send_reading(make_reading(ACT_CLASSIFY, 1000, 2000, 4800, COLOR_BLUE));
    send_reading(make_reading(ACT_CLASSIFY, 1000, 2000, 4000, COLOR_NONE));
    send_reading(make_reading(ACT_CLASSIFY, 2000, '0, '0, COLOR_RED));
    send_reading(make_reading(ACT_CLASSIFY, '0, '0, '0, COLOR_NONE));
    send_reading(make_reading(ACT_CLASSIFY, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, COLOR_GREEN));
    send_reading(make_reading(ACT_CLASSIFY, 1200, 2300, 4000, COLOR_NONE));
  endtask

  // Baselines of exactly one in Q12.12 put the comparisons right on their
  // boundaries; then both registers go to their extremes and back.
  task automatic test_threshold_edges();
    run_calibration(4096, 4096, 4096, LEVEL_W, 0);
    send_reading(make_reading(ACT_CLASSIFY, 4710, 4485, '0, COLOR_RED));
    send_reading(make_reading(ACT_CLASSIFY, 4709, 4485, '0, COLOR_NONE));
    send_reading(make_reading(ACT_CLASSIFY, 4710, 4486, '0, COLOR_RED));
    send_reading(make_reading(ACT_CLASSIFY, '0, '0, 4710, COLOR_BLUE));
    drain_results();
    // With both thresholds at zero every test passes, so red always wins.
    write_reg(REG_LEVEL_THR, '0);
    write_reg(REG_DOM_THR, '0);
    send_reading(make_reading(ACT_CLASSIFY, '0, '0, '0, COLOR_RED));
    send_reading(make_reading(ACT_CLASSIFY, 100, 5000, 5000, COLOR_GREEN));
    drain_results();
    write_reg(REG_LEVEL_THR, '1);
    write_reg(REG_DOM_THR, '1);
    send_reading(make_reading(ACT_CLASSIFY, LEVEL_MAX, '0, '0, COLOR_RED));
    send_reading(make_reading(ACT_CLASSIFY, 65534, '0, '0, COLOR_NONE));
    send_reading(make_reading(ACT_CLASSIFY, '0, 65535, '0, COLOR_GREEN));
    drain_results();
    // Writes to indexes without a register must change nothing.
    write_reg(REG_SPARE_A, '0);
    write_reg(REG_SPARE_B, 16'h1234);
    send_reading(make_reading(ACT_CLASSIFY, 65535, '0, '0, COLOR_RED));
    drain_results();
    write_reg(REG_LEVEL_THR, LEVEL_THR_RST);
    write_reg(REG_DOM_THR, DOM_THR_RST);
  endtask

  // Full-scale baselines, then a run that leaves the blue baseline at zero.
  task automatic test_extreme_baselines();
    run_calibration(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_W, 0);
    send_reading(make_reading(ACT_CLASSIFY, LEVEL_MAX, '0, '0, COLOR_RED));
    send_reading(make_reading(ACT_CLASSIFY, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, COLOR_NONE));
    run_calibration(5000, 5000, '0, LEVEL_W, 0);
    send_reading(make_reading(ACT_CLASSIFY, LEVEL_MAX, '0, '0, COLOR_NONE));
    send_reading(make_reading(ACT_CLASSIFY, '0, LEVEL_MAX, '0, COLOR_GREEN));
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the
  // output register and the datapath fill and the input stalls. Afterwards the
  // sender waits for every result before it goes on.
  task automatic test_output_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 27;
    run_calibration(2000, 3000, 1500, 4, 0);
    long_hold = 1'b1;
    for (int n = 0; n < 12; n++) begin
      if (n % 3 == 2) send_reading(make_reading(ACT_CALIB, random_base(), random_base(),
                                                random_base(), $urandom_range(0, 3)));
      else send_reading(shaped_classify());
    end
    drain_results();
  endtask

  // Mostly well-formed traffic: classify bursts and complete calibration runs,
  // with broken runs, noise words and threshold changes mixed in.
  task automatic test_random_traffic(int send_pct, int recv_pct, int words);
    int stop_at;
    int pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    drain_results();
    randomize_thresholds();
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        repeat ($urandom_range(1, 16)) send_reading(shaped_classify());
      end else if (pick < 75) begin
        run_calibration(random_base(), random_base(), random_base(),
                        $urandom_range(3, 8), 8);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 10)) begin
          send_reading(make_reading(ACT_CALIB, $urandom(), $urandom(), $urandom(),
                                    $urandom_range(0, 3)));
        end
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) send_reading(random_reading());
      end else begin
        drain_results();
        randomize_thresholds();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready generation and result checking
  // ---------------------------------------------------------------------------

  // Ready is decided at each edge. A requested long hold is counted here, in
  // cycles, and released by this process alone once it has run its course.
  initial begin : verdict_checker
    verdict_t got, want;
    int       held;
    held = 0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1) begin
        got.color    = verdict_ch.detected_color;
        got.match    = verdict_ch.matches_target;
        got.cal_done = verdict_ch.calibration_done;
        if (pending_verdicts.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("%0t: result word with nothing expected: color %0d match %0b done %0b",
                     $time, got.color, got.match, got.cal_done);
          end
        end else begin
          want = pending_verdicts.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
              $display("%0t: mismatch: color exp %0d got %0d, match exp %0b got %0b, done exp %0b got %0b",
                       $time, want.color, got.color, want.match, got.match,
                       want.cal_done, got.cal_done);
            end
          end
        end
      end
      if (long_hold) begin
        verdict_ch.ready <= 1'b0;
        held++;
        if (held >= LONG_HOLD_CYCLES) begin
          held      = 0;
          long_hold = 1'b0;
        end
      end else begin
        verdict_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Ends the run if no word moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((reading_ch.valid === 1'b1 && reading_ch.ready === 1'b1) ||
          (verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: watchdog: no word moved in %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, pending_verdicts.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : test_sequence
    // The predictor starts from the reset state of the block.
    for (int i = 0; i < 3; i++) begin
      ch_sum[i]  = '0;
      ch_base[i] = '0;
    end
    samples_taken = '0;
    level_thr     = LEVEL_THR_RST;
    dom_thr       = DOM_THR_RST;

    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_LEVEL_THR;
    cfg_data         <= '0;
    reading_ch.valid <= 1'b0;
    drive_payload(random_reading());
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_uncalibrated();
    test_first_calibration();
    test_basic_classify();
    test_threshold_edges();
    test_extreme_baselines();
    test_output_stall();
    test_random_traffic(0, 0, PHASE_WORDS);
    test_random_traffic(84, 0, PHASE_WORDS);
    test_random_traffic(0, 84, PHASE_WORDS);
    test_random_traffic(27, 27, PHASE_WORDS);

    // Let the pipeline settle; a stray result in this window is still caught.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d words: %0d calibration samples closing %0d runs, %0d classify requests.",
             words_sent, calib_words, runs_closed, classify_words);
    $display("Predicted colors red %0d, green %0d, blue %0d, none %0d over %0d threshold writes.",
             color_hits[COLOR_RED], color_hits[COLOR_GREEN], color_hits[COLOR_BLUE],
             color_hits[COLOR_NONE], settings_used);
    if (failures == 0 && pending_verdicts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
